>>> hw/rtl/sps_pkg.sv
package sps_pkg;

  localparam int unsigned PatternMaxDefault     = 16;
  localparam int unsigned StringCountMaxDefault = 65536;

  localparam logic [7:0]  FoldBit     = 8'h20;
  localparam logic [14:0] OffsetLimit = 15'h7fff;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 64;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgPatternLow    = 3'd0,
    CfgPatternHigh   = 3'd1,
    CfgPatternLength = 3'd2,
    CfgMatchMode     = 3'd3,
    CfgContextTag    = 3'd4
  } cfg_reg_e;

endpackage

>>> hw/rtl/string_pool_pattern_search.sv
// Streams a pool of zero-terminated strings one byte per transfer and reports every
// start position of the configured pattern (up to PatternMax bytes), either as a
// case-folded substring (each pool byte ORed with 0x20 against the pattern byte) or as
// an exact match that ends right before a terminator. A result carries the index of
// the string holding the match start, the start offset within it (saturating at 32767)
// and a copy of context_tag. Throughput is one byte per cycle: the pattern compare over
// the shift window sits between the window registers and the result register, so a
// result appears in the cycle after the byte that completes it. The input stalls only
// while a result is waiting and the output side stalls too. The byte marked last_byte
// ends the pool: counters and window restart after it. Program the registers while
// the block is idle; a pattern_length of zero or above PatternMax never matches.
module string_pool_pattern_search
  import sps_pkg::*;
#(
  parameter int unsigned PatternMax     = PatternMaxDefault,
  parameter int unsigned StringCountMax = StringCountMaxDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [15:0]              string_index_o,
  output logic [14:0]              string_offset_o,
  output logic signed [15:0]       result_tag_o
);

  localparam int unsigned Win  = PatternMax + 1;
  localparam int unsigned WinW = (Win > 1) ? $clog2(Win) : 1;
  localparam int unsigned SeenW = $clog2(Win + 1);
  localparam logic [SeenW-1:0] SeenMax = SeenW'(Win);
  localparam logic [15:0] IdxLimit =
    (StringCountMax - 1 > 65535) ? 16'hffff : 16'(StringCountMax - 1);

  logic [63:0]        pattern_low_q, pattern_high_q;
  logic [4:0]         pattern_length_q;
  logic               match_mode_q;
  logic signed [15:0] context_tag_q;

  logic [7:0]  win_byte_q [Win];
  logic [15:0] win_idx_q  [Win];
  logic [14:0] win_off_q  [Win];
  logic [7:0]  win_byte_d [Win];
  logic [15:0] win_idx_d  [Win];
  logic [14:0] win_off_d  [Win];

  logic [15:0]      cur_idx_q, cur_idx_d;
  logic [14:0]      cur_off_q, cur_off_d;
  logic [SeenW-1:0] seen_q, seen_d, seen_n;

  logic        out_valid_q;
  logic [15:0] out_idx_q;
  logic [14:0] out_off_q;
  logic signed [15:0] out_tag_q;

  logic         in_acc;
  logic         match;
  logic [127:0] pattern;
  logic [5:0]   start;
  logic [5:0]   pos;
  logic [7:0]   cmp_byte;
  logic [WinW-1:0] start_sel;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign pattern     = {pattern_high_q, pattern_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      pattern_length_q <= '0;
      match_mode_q     <= 1'b0;
      context_tag_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgPatternLow:    pattern_low_q    <= cfg_data_i;
        CfgPatternHigh:   pattern_high_q   <= cfg_data_i;
        CfgPatternLength: pattern_length_q <= cfg_data_i[4:0];
        CfgMatchMode:     match_mode_q     <= cfg_data_i[0];
        CfgContextTag:    context_tag_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // shifted window including the incoming byte
  always_comb begin
    win_byte_d[0] = data_byte_i;
    win_idx_d[0]  = cur_idx_q;
    win_off_d[0]  = cur_off_q;
    for (int k = 1; k < Win; k++) begin
      win_byte_d[k] = win_byte_q[k-1];
      win_idx_d[k]  = win_idx_q[k-1];
      win_off_d[k]  = win_off_q[k-1];
    end
    seen_n = (seen_q < SeenMax) ? seen_q + SeenW'(1) : seen_q;
  end

  always_comb begin
    cur_idx_d = cur_idx_q;
    cur_off_d = cur_off_q;
    seen_d    = seen_n;
    if (last_byte_i) begin
      cur_idx_d = '0;
      cur_off_d = '0;
      seen_d    = '0;
    end else if (data_byte_i == 8'h00) begin
      if (cur_idx_q < IdxLimit) cur_idx_d = cur_idx_q + 16'd1;
      cur_off_d = '0;
    end else if (cur_off_q < OffsetLimit) begin
      cur_off_d = cur_off_q + 15'd1;
    end
  end

  // compare of all pattern bytes against the window
  always_comb begin
    start = match_mode_q ? {1'b0, pattern_length_q} : {1'b0, pattern_length_q} - 6'd1;
    start_sel = start[WinW-1:0];
    match = (pattern_length_q != 5'd0) && (32'(pattern_length_q) <= PatternMax) &&
            (6'(seen_n) > start) && (!match_mode_q || data_byte_i == 8'h00);
    pos = '0;
    cmp_byte = '0;
    for (int i = 0; i < PatternMax; i++) begin
      if (5'(i) < pattern_length_q) begin
        pos = start - 6'(i);
        cmp_byte = win_byte_d[pos[WinW-1:0]];
        if (!match_mode_q) cmp_byte = cmp_byte | FoldBit;
        if (cmp_byte != pattern[8*i +: 8]) match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < Win; k++) begin
        win_byte_q[k] <= win_byte_d[k];
        win_idx_q[k]  <= win_idx_d[k];
        win_off_q[k]  <= win_off_d[k];
      end
      out_idx_q <= win_idx_d[start_sel];
      out_off_q <= win_off_d[start_sel];
      out_tag_q <= context_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_idx_q   <= '0;
      cur_off_q   <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cur_idx_q   <= cur_idx_d;
        cur_off_q   <= cur_off_d;
        seen_q      <= seen_d;
        out_valid_q <= match;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign string_index_o  = out_idx_q;
  assign string_offset_o = out_off_q;
  assign result_tag_o    = out_tag_q;

  a_stall_only_on_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  a_pool_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=> (seen_q == '0 && cur_idx_q == '0 && cur_off_q == '0))
    else $error("stream state not cleared after last byte");

  a_empty_never_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pattern_length_q == 5'd0) |=> !out_valid_o)
    else $error("result for empty pattern");

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SeenMax)
    else $error("window fill count out of range");

  a_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_idx_q <= IdxLimit)
    else $error("string index beyond limit");

endmodule
